>>> src/lamp_node_registration_fsm_top_assert.svh
// Assertion macros for the lamp node registration block.
`ifndef LAMP_NODE_REGISTRATION_FSM_TOP_ASSERT_SVH
`define LAMP_NODE_REGISTRATION_FSM_TOP_ASSERT_SVH

// Clocked check, masked while reset is asserted
`define LNR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define LNR_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/lnr_pkg.sv
// Types and constants shared by the lamp node registration block.
package lnr_pkg;

	// Lamp modes
	typedef enum logic [2:0] {
		MODE_IDLE   = 3'd0,
		MODE_UNREG  = 3'd1,
		MODE_REGING = 3'd2,
		MODE_OFF    = 3'd3,
		MODE_ON     = 3'd4,
		MODE_FAULT  = 3'd5
	} mode_t;

	// Input events
	typedef enum logic [2:0] {
		OP_TICK         = 3'd0,
		OP_LINK_UP      = 3'd1,
		OP_LINK_DOWN    = 3'd2,
		OP_REG_ACK      = 3'd3,
		OP_REG_NACK     = 3'd4,
		OP_COMMAND      = 3'd5,
		OP_FAULT        = 3'd6,
		OP_MANUAL_RESET = 3'd7
	} op_t;

	// Result actions
	typedef enum logic [2:0] {
		ACT_NONE     = 3'd0,
		ACT_REGISTER = 3'd1,
		ACT_STATUS   = 3'd2,
		ACT_FAULT    = 3'd3,
		ACT_CLOSE    = 3'd4,
		ACT_CONNECT  = 3'd5
	} action_t;

	// Configuration register indexes
	localparam logic [1:0] REG_HEARTBEAT_PERIOD = 2'd0;
	localparam logic [1:0] REG_REGISTER_TIMEOUT = 2'd1;
	localparam logic [1:0] REG_RECONNECT_DELAY  = 2'd2;
	localparam logic [1:0] REG_MIN_ON_LEVEL     = 2'd3;

	// Configuration reset values
	localparam logic [7:0] RST_HEARTBEAT_PERIOD = 8'd10;
	localparam logic [7:0] RST_REGISTER_TIMEOUT = 8'd5;
	localparam logic [7:0] RST_RECONNECT_DELAY  = 8'd2;
	localparam logic [7:0] RST_MIN_ON_LEVEL     = 8'd30;

	// Command codes
	localparam logic [7:0] CMD_SWITCH_ON  = 8'd1;
	localparam logic [7:0] CMD_SWITCH_OFF = 8'd2;
	localparam logic [7:0] CMD_SET_LEVEL  = 8'd3;

	// Power estimate
	localparam logic [18:0] POWER_BASE_MW      = 19'd70000;
	localparam logic [18:0] POWER_PER_LEVEL_MW = 19'd800;

	typedef struct packed {
		logic [7:0] heartbeat_period;
		logic [7:0] register_timeout;
		logic [7:0] reconnect_delay;
		logic [7:0] min_on_level;
	} cfg_t;

	typedef struct packed {
		op_t        operation;
		logic [7:0] command_code;
		logic [7:0] command_level;
	} item_t;

	typedef struct packed {
		action_t     action;
		mode_t       lamp_mode;
		logic        lamp_on;
		logic [7:0]  level;
		logic [18:0] power_est;
		logic        fault_code;
	} result_t;

endpackage

>>> src/lamp_node_registration_fsm_top.sv
// Result path: an accepted event waits in the input register, then its result is captured in the result register.
// Throughput: one event per cycle unless out_stall holds the result register; next state is combinational.
// in_stall rises only when both the input register and result register are held.
// Reset: asynchronous active low; mode unregistered, intensity and timers zero,
// a connect request pending for the first tick, config registers at defaults.
`include "lamp_node_registration_fsm_top_assert.svh"

// Top level of the lamp node registration block.
module lamp_node_registration_fsm_top
	import lnr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  operation,
	input  logic [7:0]  command_code,
	input  logic [7:0]  command_level,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  action,
	output logic [2:0]  lamp_mode,
	output logic        lamp_on,
	output logic [7:0]  level,
	output logic [18:0] power_est,
	output logic        fault_code
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_core;
	result_t res_s2;
	logic    valid_s2;
	logic    in_take;
	logic    adv_s1;

	lnr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Handshake control
	assign adv_s1   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign in_take  = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.operation     <= op_t'(operation);
			item_s1.command_code  <= command_code;
			item_s1.command_level <= command_level;
		end
	end

	lnr_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv_s1),
		.item   (item_s1),
		.cfg    (cfg),
		.result (res_core)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_core;
		end
	end

	assign out_valid  = valid_s2;
	assign action     = res_s2.action;
	assign lamp_mode  = res_s2.lamp_mode;
	assign lamp_on    = res_s2.lamp_on;
	assign level      = res_s2.level;
	assign power_est  = res_s2.power_est;
	assign fault_code = res_s2.fault_code;

	// Checks
	`LNR_ASSERT(a_on_flag, out_valid |-> (lamp_on == (lamp_mode == MODE_ON)), "lamp_on mismatch")
	`LNR_ASSERT(a_fault_rpt, out_valid && fault_code |-> action == ACT_FAULT, "stray fault code")
	`LNR_ASSERT(a_power_off, out_valid && !lamp_on |-> power_est == 19'd0, "power while off")
	`LNR_ASSERT_ALWAYS(a_stall_src, in_stall |-> out_stall && out_valid, "stray input stall")

endmodule

>>> src/lnr_cfg.sv
// Configuration register file of the lamp node registration block.
module lnr_cfg
	import lnr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_wdata,
	output cfg_t       cfg
);

	logic [7:0] heartbeat_period_q;
	logic [7:0] register_timeout_q;
	logic [7:0] reconnect_delay_q;
	logic [7:0] min_on_level_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heartbeat_period_q <= RST_HEARTBEAT_PERIOD;
			register_timeout_q <= RST_REGISTER_TIMEOUT;
			reconnect_delay_q  <= RST_RECONNECT_DELAY;
			min_on_level_q     <= RST_MIN_ON_LEVEL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HEARTBEAT_PERIOD: heartbeat_period_q <= cfg_wdata;
				REG_REGISTER_TIMEOUT: register_timeout_q <= cfg_wdata;
				REG_RECONNECT_DELAY:  reconnect_delay_q  <= cfg_wdata;
				REG_MIN_ON_LEVEL:     min_on_level_q     <= cfg_wdata;
				default:              ;
			endcase
		end
	end

	assign cfg.heartbeat_period = heartbeat_period_q;
	assign cfg.register_timeout = register_timeout_q;
	assign cfg.reconnect_delay  = reconnect_delay_q;
	assign cfg.min_on_level     = min_on_level_q;

endmodule

>>> src/lnr_core.sv
// Lamp state machine: mode, intensity and tick counters, one event per cycle while step is high.
module lnr_core
	import lnr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t result
);

	mode_t      mode_q,          mode_d;
	logic [7:0] intensity_q,     intensity_d;
	logic [7:0] reg_timer_q,     reg_timer_d;
	logic [7:0] hb_timer_q,      hb_timer_d;
	logic       hb_active_q,     hb_active_d;
	logic [7:0] rc_timer_q,      rc_timer_d;
	logic       rc_pending_q,    rc_pending_d;

	logic       reg_fire;
	logic       rc_fire;
	logic       hb_fire;
	logic       lamp_live;
	action_t    action;

	// Counter expiry on this tick (a counter at 0 or 1 expires)
	assign reg_fire  = (mode_q == MODE_REGING) && (reg_timer_q <= 8'd1);
	assign rc_fire   = rc_pending_q && (rc_timer_q <= 8'd1);
	assign hb_fire   = hb_active_q && (hb_timer_q <= 8'd1);
	assign lamp_live = (mode_q == MODE_ON) || (mode_q == MODE_OFF);

	// Next state
	always_comb begin
		mode_d       = mode_q;
		intensity_d  = intensity_q;
		reg_timer_d  = reg_timer_q;
		hb_timer_d   = hb_timer_q;
		hb_active_d  = hb_active_q;
		rc_timer_d   = rc_timer_q;
		rc_pending_d = rc_pending_q;
		unique case (item.operation)
			OP_TICK: begin
				if (mode_q == MODE_REGING) begin
					reg_timer_d = reg_fire ? 8'd0 : reg_timer_q - 8'd1;
				end
				if (rc_pending_q) begin
					rc_timer_d = rc_fire ? 8'd0 : rc_timer_q - 8'd1;
					if (rc_fire) begin
						rc_pending_d = 1'b0;
					end
				end
				if (hb_active_q) begin
					if (hb_fire) begin
						hb_active_d = (cfg.heartbeat_period != 8'd0);
						hb_timer_d  = cfg.heartbeat_period;
					end else begin
						hb_timer_d = hb_timer_q - 8'd1;
					end
				end
				// Register timeout wins: close and schedule a reconnect
				if (reg_fire) begin
					mode_d       = MODE_UNREG;
					reg_timer_d  = 8'd0;
					hb_active_d  = 1'b0;
					hb_timer_d   = 8'd0;
					rc_pending_d = 1'b1;
					rc_timer_d   = cfg.reconnect_delay;
				end
			end
			OP_LINK_UP: begin
				if (mode_q != MODE_REGING) begin
					mode_d      = MODE_REGING;
					reg_timer_d = cfg.register_timeout;
				end
			end
			OP_LINK_DOWN, OP_REG_NACK: begin
				mode_d       = MODE_UNREG;
				reg_timer_d  = 8'd0;
				hb_active_d  = 1'b0;
				hb_timer_d   = 8'd0;
				rc_pending_d = 1'b1;
				rc_timer_d   = cfg.reconnect_delay;
			end
			OP_REG_ACK: begin
				if (mode_q == MODE_REGING) begin
					reg_timer_d = 8'd0;
					mode_d      = MODE_OFF;
					intensity_d = 8'd0;
					hb_active_d = (cfg.heartbeat_period != 8'd0);
					hb_timer_d  = cfg.heartbeat_period;
				end
			end
			OP_COMMAND: begin
				unique case (item.command_code)
					CMD_SWITCH_ON: begin
						if (mode_q == MODE_OFF) begin
							mode_d = MODE_ON;
							if (intensity_q < cfg.min_on_level) begin
								intensity_d = cfg.min_on_level;
							end
						end
					end
					CMD_SWITCH_OFF: begin
						if (mode_q == MODE_ON) begin
							mode_d      = MODE_OFF;
							intensity_d = 8'd0;
						end
					end
					CMD_SET_LEVEL: begin
						intensity_d = item.command_level;
						if ((item.command_level == 8'd0) && (mode_q == MODE_ON)) begin
							mode_d = MODE_OFF;
						end else if ((item.command_level != 8'd0) && (mode_q == MODE_OFF)) begin
							mode_d = MODE_ON;
						end
					end
					default: ;
				endcase
			end
			OP_FAULT: begin
				if (lamp_live) begin
					mode_d = MODE_FAULT;
				end
			end
			OP_MANUAL_RESET: begin
				if (mode_q == MODE_FAULT) begin
					mode_d       = MODE_UNREG;
					reg_timer_d  = 8'd0;
					hb_active_d  = 1'b0;
					hb_timer_d   = 8'd0;
					rc_pending_d = 1'b1;
					rc_timer_d   = cfg.reconnect_delay;
				end
			end
			default: ;
		endcase
	end

	// Action for the event
	always_comb begin
		action = ACT_NONE;
		unique case (item.operation)
			OP_TICK: begin
				if (reg_fire) begin
					action = ACT_CLOSE;
				end else if (rc_fire) begin
					action = ACT_CONNECT;
				end else if (hb_fire && lamp_live) begin
					action = ACT_STATUS;
				end
			end
			OP_LINK_UP: begin
				if (mode_q != MODE_REGING) begin
					action = ACT_REGISTER;
				end
			end
			OP_LINK_DOWN, OP_REG_NACK: action = ACT_CLOSE;
			OP_REG_ACK: begin
				if (mode_q == MODE_REGING) begin
					action = ACT_STATUS;
				end
			end
			OP_COMMAND: begin
				unique case (item.command_code)
					CMD_SWITCH_ON:  if (mode_q == MODE_OFF) action = ACT_STATUS;
					CMD_SWITCH_OFF: if (mode_q == MODE_ON) action = ACT_STATUS;
					// set level may switch the lamp between on and off, but never out of the on/off modes
					CMD_SET_LEVEL:  if (lamp_live) action = ACT_STATUS;
					default:        ;
				endcase
			end
			OP_FAULT: begin
				if (lamp_live) begin
					action = ACT_FAULT;
				end
			end
			OP_MANUAL_RESET: begin
				if (mode_q == MODE_FAULT) begin
					action = ACT_CLOSE;
				end
			end
			default: ;
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_UNREG;
			intensity_q  <= 8'd0;
			reg_timer_q  <= 8'd0;
			hb_timer_q   <= 8'd0;
			hb_active_q  <= 1'b0;
			rc_timer_q   <= 8'd0;
			rc_pending_q <= 1'b1;
		end else if (step) begin
			mode_q       <= mode_d;
			intensity_q  <= intensity_d;
			reg_timer_q  <= reg_timer_d;
			hb_timer_q   <= hb_timer_d;
			hb_active_q  <= hb_active_d;
			rc_timer_q   <= rc_timer_d;
			rc_pending_q <= rc_pending_d;
		end
	end

	// Result fields reflect the state after the event
	assign result.action     = action;
	assign result.lamp_mode  = mode_d;
	assign result.lamp_on    = (mode_d == MODE_ON);
	assign result.level      = intensity_d;
	assign result.power_est  = (mode_d == MODE_ON)
		? POWER_BASE_MW + POWER_PER_LEVEL_MW * {11'd0, intensity_d}
		: 19'd0;
	assign result.fault_code = (action == ACT_FAULT);

endmodule
